// ===== rtl/fir_filter_circular_macros.svh =====
// Assertion macros used by the checker file of the FIR filter.
`ifndef FIR_FILTER_CIRCULAR_MACROS_SVH
`define FIR_FILTER_CIRCULAR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define FIRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("firc assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define FIRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("firc assertion failed");

`endif

// ===== rtl/firc_pkg.sv =====
// Package with the constants, types and control structs of the FIR filter.
`default_nettype none

package firc_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int MAX_TAPS      = 64;

  localparam int HIST_AW   = $clog2(HISTORY_DEPTH);
  localparam int COEF_AW   = $clog2(MAX_TAPS);
  localparam int TAP_W     = $clog2(MAX_TAPS + 1);
  localparam int CFG_W     = 7;
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int OUT_W     = 16;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = PROD_W + COEF_AW;
  localparam int FRAC_BITS = 15;
  localparam int RES_W     = ACC_W + 1 - FRAC_BITS;

  localparam logic [ACC_W:0] ROUND_BIAS = (ACC_W + 1)'(1) << (FRAC_BITS - 1);

  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND
  } state_t;

  typedef struct packed {
    logic               hist_we;
    logic [HIST_AW-1:0] wr_pos;
    logic               coef_we;
    logic               issue;
    logic [HIST_AW-1:0] hist_addr;
    logic [COEF_AW-1:0] coef_addr;
    logic               acc_clr;
    logic               finish;
  } firc_ctl_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } firc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/firc_ifs.sv =====
// Valid/ready channel interfaces for the input and result words of the FIR filter.
`default_nettype none

interface firc_in_if;
  import firc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [COEF_AW-1:0]         coef_index;
  logic signed [COEF_W-1:0]   coef_value;

  modport source (output valid, output opcode, output sample_in, output coef_index,
                  output coef_value, input ready);
  modport sink (input valid, input opcode, input sample_in, input coef_index,
                input coef_value, output ready);
endinterface

interface firc_out_if;
  import firc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] filtered_out;
  logic                    saturated;

  modport source (output valid, output filtered_out, output saturated, input ready);
  modport sink (input valid, input filtered_out, input saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/firc_ctrl.sv =====
// Sequencer that steps the shared multiply-accumulate unit over the taps.
`default_nettype none

module firc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_opcode,
  output logic                   in_ready,
  input  logic                   cfg_we,
  input  logic [firc_pkg::CFG_W-1:0] cfg_wdata,
  input  firc_pkg::firc_sts_t    sts,
  output firc_pkg::firc_ctl_t    ctl
);
  import firc_pkg::*;

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   tap_count_r;
  logic [TAP_W-1:0]   taps_r, taps_nxt;
  logic [TAP_W-1:0]   k_r, k_nxt;
  logic [HIST_AW-1:0] wp_r, wp_nxt;
  logic [HIST_AW-1:0] pos_r, pos_nxt;
  logic [TAP_W-1:0]   taps_sat;
  logic               accept;
  logic               sample_acc;
  logic               load_acc;

  assign accept     = in_valid && in_ready;
  assign sample_acc = accept && (op_t'(in_opcode) == OP_FILTER);
  assign load_acc   = accept && (op_t'(in_opcode) == OP_LOAD);
  assign taps_sat   = (tap_count_r > CFG_W'(MAX_TAPS)) ? TAP_W'(MAX_TAPS)
                                                       : TAP_W'(tap_count_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (sample_acc) begin
          state_nxt = (taps_sat == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (k_r == taps_r - TAP_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    taps_nxt = taps_r;
    k_nxt    = k_r;
    wp_nxt   = wp_r;
    pos_nxt  = pos_r;
    case (state_r)
      ST_IDLE: begin
        if (sample_acc) begin
          taps_nxt = taps_sat;
          k_nxt    = '0;
          pos_nxt  = wp_r;
          wp_nxt   = wp_r + HIST_AW'(1);
        end
      end
      ST_RUN: begin
        k_nxt = k_r + TAP_W'(1);
      end
      default: begin
        k_nxt = k_r;
      end
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    ctl.hist_we   = sample_acc;
    ctl.wr_pos    = wp_r;
    ctl.coef_we   = load_acc;
    ctl.issue     = (state_r == ST_RUN);
    ctl.hist_addr = pos_r - k_r[HIST_AW-1:0];
    ctl.coef_addr = k_r[COEF_AW-1:0];
    ctl.acc_clr   = sample_acc;
    ctl.finish    = (state_r == ST_ROUND);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_count_r <= CFG_W'(1);
      wp_r        <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      if (cfg_we) begin
        tap_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    taps_r <= taps_nxt;
    k_r    <= k_nxt;
    pos_r  <= pos_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/firc_dp.sv =====
// Datapath with the sample history, the coefficient store, the shared MAC and the output register.
`default_nettype none

module firc_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  firc_pkg::firc_ctl_t                ctl,
  output firc_pkg::firc_sts_t                sts,
  input  logic signed [firc_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [firc_pkg::COEF_AW-1:0]       coef_index,
  input  logic signed [firc_pkg::COEF_W-1:0] coef_value,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [firc_pkg::OUT_W-1:0]  filtered_out,
  output logic                               saturated
);
  import firc_pkg::*;

  logic signed [SAMPLE_W-1:0] hist_mem [HISTORY_DEPTH];
  logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
  logic [HISTORY_DEPTH-1:0]   hist_vld_r;

  logic signed [SAMPLE_W-1:0] rd_h_r;
  logic signed [COEF_W-1:0]   rd_c_r;
  logic                       rd_hv_r;
  logic                       rd_v_r;
  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       prod_v_r;
  logic signed [ACC_W-1:0]    acc_r;

  logic signed [ACC_W:0]      biased;
  logic signed [RES_W-1:0]    res;
  logic                       sat_hi;
  logic                       sat_lo;
  logic                       out_free;
  logic                       out_load;
  logic                       out_valid_r;
  logic signed [OUT_W-1:0]    filtered_out_r;
  logic                       saturated_r;

  always_ff @(posedge clk) begin
    if (ctl.hist_we) begin
      hist_mem[ctl.wr_pos] <= sample_in;
    end
    rd_h_r <= hist_mem[ctl.hist_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.coef_we) begin
      coef_mem[coef_index] <= coef_value;
    end
    rd_c_r <= coef_mem[ctl.coef_addr];
  end

  // Entries never written since reset read as zero.
  assign mul_a = rd_hv_r ? rd_h_r : '0;

  always_ff @(posedge clk) begin
    rd_hv_r <= hist_vld_r[ctl.hist_addr];
    prod_r  <= mul_a * rd_c_r;
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
      rd_v_r     <= 1'b0;
      prod_v_r   <= 1'b0;
    end else begin
      rd_v_r   <= ctl.issue;
      prod_v_r <= rd_v_r;
      if (ctl.hist_we) begin
        hist_vld_r[ctl.wr_pos] <= 1'b1;
      end
    end
  end

  // Round half up, then clip to the signed output range.
  assign biased = $signed({acc_r[ACC_W-1], acc_r}) + $signed(ROUND_BIAS);
  assign res    = biased[ACC_W:FRAC_BITS];
  assign sat_hi = !res[RES_W-1] && (|res[RES_W-2:OUT_W-1]);
  assign sat_lo = res[RES_W-1] && !(&res[RES_W-2:OUT_W-1]);

  assign out_free = !out_valid_r || out_ready;
  assign out_load = ctl.finish && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      saturated_r <= sat_hi || sat_lo;
      if (sat_hi) begin
        filtered_out_r <= {1'b0, {(OUT_W-1){1'b1}}};
      end else if (sat_lo) begin
        filtered_out_r <= {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        filtered_out_r <= res[OUT_W-1:0];
      end
    end
  end

  assign sts.pipe_busy = rd_v_r || prod_v_r;
  assign sts.out_free  = out_free;
  assign out_valid     = out_valid_r;
  assign filtered_out  = filtered_out_r;
  assign saturated     = saturated_r;

endmodule

`default_nettype wire

// ===== rtl/fir_filter_circular.sv =====
// With t = min(tap_count, 64), a sample word is taken while the input is ready; its result turns
// valid once the rounded sum is loaded into the output register, and the input is ready again in
// that same cycle. Samples do not overlap: the single multiply-accumulate takes one tap per cycle
// over the t taps (none when t is 0), the read, multiply and rounding stages then finish, and a
// result still held by a stalled output adds its wait. A coefficient load word gives no result.
// Reset (rst_n low, synchronous) clears the history and write position and sets tap_count to 1.
`default_nettype none

module fir_filter_circular (
  input  logic                       clk,
  input  logic                       rst_n,
  firc_in_if.sink                    in_ch,
  firc_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [firc_pkg::CFG_W-1:0] cfg_wdata
);
  import firc_pkg::*;

  firc_ctl_t ctl;
  firc_sts_t sts;

  firc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .ctl       (ctl)
  );

  firc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .sts          (sts),
    .sample_in    (in_ch.sample_in),
    .coef_index   (in_ch.coef_index),
    .coef_value   (in_ch.coef_value),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .filtered_out (out_ch.filtered_out),
    .saturated    (out_ch.saturated)
  );

endmodule

`default_nettype wire

// ===== rtl/firc_checker.sv =====
// Port-level checker for the FIR filter and the bind that attaches it.
`default_nettype none
`include "fir_filter_circular_macros.svh"

module firc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_opcode,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [firc_pkg::OUT_W-1:0]     filtered_out,
  input logic                           saturated
);
  import firc_pkg::*;

  logic in_acc;
  logic sample_acc;
  logic load_acc;
  logic out_stall;
  logic at_limit;

  assign in_acc     = in_valid && in_ready;
  assign sample_acc = in_acc && (op_t'(in_opcode) == OP_FILTER);
  assign load_acc   = in_acc && (op_t'(in_opcode) == OP_LOAD);
  assign out_stall  = out_valid && !out_ready;
  assign at_limit   = (filtered_out == {1'b0, {(OUT_W-1){1'b1}}}) ||
                      (filtered_out == {1'b1, {(OUT_W-1){1'b0}}});

  // A sample word keeps the input closed while its taps are summed.
  `FIRC_ASSERT_NEXT(a_sample_busy, sample_acc, !in_ready)
  // A coefficient load never produces a result word.
  `FIRC_ASSERT_NEXT(a_load_silent, load_acc && !out_valid, !out_valid)
  // A clipped result sits at one of the two range limits.
  `FIRC_ASSERT_NOW(a_sat_limit, out_valid && saturated, at_limit)
  `FIRC_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(filtered_out) && $stable(saturated))

endmodule

bind fir_filter_circular firc_checker u_firc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_opcode    (in_ch.opcode),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .filtered_out (out_ch.filtered_out),
  .saturated    (out_ch.saturated)
);

`default_nettype wire
